/* hdl/clipped_box_blur_macros.svh */
// ----------------------------------------------------------------------------
// Clipped box blur assertion macros
// Shared property macros for the blur block. They expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_BOX_BLUR_MACROS_SVH
`define CLIPPED_BOX_BLUR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBB_ASSERT_NOW(label, cond, chk, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (chk)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBB_ASSERT_NEXT(label, cond, chk, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (chk)) \
    else $error(msg);

`endif

/* hdl/cbb_pkg.sv */
// ----------------------------------------------------------------------------
// Clipped box blur package
// Sizes, codes, state encoding and interface structs shared by the blur block.
// ----------------------------------------------------------------------------
package cbb_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int MAX_RADIUS  = 7;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int COL_W  = 6;
  localparam int ROW_W  = 6;
  localparam int SIZE_W = 7;
  localparam int RAD_W  = 3;
  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int SUM_W  = 2 * CH_W;
  localparam int CNT_W  = 8;
  localparam int NUM_CH = 3;
  localparam int CHSEL_W = $clog2(NUM_CH);
  localparam int STEP_W = $clog2(CH_W);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = SIZE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUR_RADIUS   = 2'd2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CHSEL_W-1:0] CH_RED   = 2'd0;
  localparam logic [CHSEL_W-1:0] CH_GREEN = 2'd1;
  localparam logic [CHSEL_W-1:0] CH_BLUE  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_RESULT
  } cbb_state_t;

  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [RAD_W-1:0]  radius;
  } cbb_cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [PIX_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } cbb_store_req_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } cbb_div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [CH_W-1:0] quotient;
  } cbb_div_rsp_t;

  function automatic logic [ADDR_W-1:0] store_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
    store_addr = ADDR_W'(r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c);
  endfunction

endpackage

/* hdl/cbb_store.sv */
// ----------------------------------------------------------------------------
// Clipped box blur frame store
// Single write port, single read port pixel memory with registered read data.
// ----------------------------------------------------------------------------
module cbb_store (
  input  logic                         clk,
  input  cbb_pkg::cbb_store_req_t      req,
  output logic [cbb_pkg::PIX_W-1:0]    rdata
);
  import cbb_pkg::*;

  logic [PIX_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

/* hdl/cbb_div.sv */
// ----------------------------------------------------------------------------
// Clipped box blur divider
// Restoring divider producing one quotient bit per cycle for a channel mean.
// ----------------------------------------------------------------------------
module cbb_div (
  input  logic                  clk,
  input  logic                  rst,
  input  cbb_pkg::cbb_div_req_t req,
  output cbb_pkg::cbb_div_rsp_t rsp
);
  import cbb_pkg::*;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CH_W - 1);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [CH_W-1:0]   rem;
  logic [CH_W-1:0]   low;
  logic [CH_W-1:0]   quo;
  logic [CNT_W-1:0]  dvs;
  logic [CH_W:0]     trial;
  logic [CH_W:0]     diff;
  logic              qbit;
  logic [CH_W-1:0]   rem_next;

  // The mean never exceeds a channel value, so the upper dividend byte is
  // already below the divisor and only the low byte needs quotient bits.
  always_comb begin
    trial    = {rem, low[CH_W-1]};
    diff     = trial - {1'b0, dvs};
    qbit     = (trial >= {1'b0, dvs});
    rem_next = qbit ? diff[CH_W-1:0] : trial[CH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.dividend[SUM_W-1:CH_W];
      low <= req.dividend[CH_W-1:0];
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      low <= {low[CH_W-2:0], 1'b0};
      quo <= {quo[CH_W-2:0], qbit};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

/* hdl/cbb_ctrl.sv */
// ----------------------------------------------------------------------------
// Clipped box blur sequencer
// Takes items, writes loads to the store, scans the clipped window of a query,
// sums the channels and runs the shared divider once per channel.
// ----------------------------------------------------------------------------
module cbb_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  cbb_pkg::cbb_cfg_t             cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [cbb_pkg::COL_W-1:0]     col,
  input  logic [cbb_pkg::ROW_W-1:0]     row,
  input  logic [cbb_pkg::CH_W-1:0]      red_in,
  input  logic [cbb_pkg::CH_W-1:0]      green_in,
  input  logic [cbb_pkg::CH_W-1:0]      blue_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cbb_pkg::COL_W-1:0]     out_col,
  output logic [cbb_pkg::ROW_W-1:0]     out_row,
  output logic [cbb_pkg::CH_W-1:0]      red_out,
  output logic [cbb_pkg::CH_W-1:0]      green_out,
  output logic [cbb_pkg::CH_W-1:0]      blue_out,
  output cbb_pkg::cbb_store_req_t       store_req,
  input  logic [cbb_pkg::PIX_W-1:0]     store_rdata,
  output cbb_pkg::cbb_div_req_t         div_req,
  input  cbb_pkg::cbb_div_rsp_t         div_rsp
);
  import cbb_pkg::*;

  cbb_state_t state, state_next;

  logic [COL_W-1:0]   q_col;
  logic [ROW_W-1:0]   q_row;
  logic [COL_W-1:0]   x0, x1, cur_x;
  logic [ROW_W-1:0]   y1, cur_y;
  logic               rd_pend;
  logic [SUM_W-1:0]   rsum, gsum, bsum;
  logic [CNT_W-1:0]   cnt;
  logic [CHSEL_W-1:0] ch;
  logic [CH_W-1:0]    mean_r, mean_g, mean_b;

  logic [SIZE_W-1:0]  w_c, h_c, rad_c;
  logic [RAD_W-1:0]   r_c;
  logic [SIZE_W-1:0]  cx, cy, x0_c, x1_c, y0_c, y1_c;
  logic               accept, take_query, load_ok, result_go, scan_last;

  always_comb begin
    if (cfg.width == '0) begin
      w_c = SIZE_W'(1);
    end else if (cfg.width > SIZE_W'(MAX_WIDTH)) begin
      w_c = SIZE_W'(MAX_WIDTH);
    end else begin
      w_c = cfg.width;
    end
    if (cfg.height == '0) begin
      h_c = SIZE_W'(1);
    end else if (cfg.height > SIZE_W'(MAX_HEIGHT)) begin
      h_c = SIZE_W'(MAX_HEIGHT);
    end else begin
      h_c = cfg.height;
    end
    r_c   = (cfg.radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : cfg.radius;
    rad_c = SIZE_W'(r_c);
    cx    = (SIZE_W'(col) < w_c) ? SIZE_W'(col) : w_c - 1'b1;
    cy    = (SIZE_W'(row) < h_c) ? SIZE_W'(row) : h_c - 1'b1;
    x0_c  = (cx > rad_c) ? cx - rad_c : '0;
    y0_c  = (cy > rad_c) ? cy - rad_c : '0;
    x1_c  = (cx + rad_c < w_c) ? cx + rad_c : w_c - 1'b1;
    y1_c  = (cy + rad_c < h_c) ? cy + rad_c : h_c - 1'b1;
  end

  assign accept     = in_valid && in_ready;
  assign take_query = accept && (op == OP_QUERY);
  assign load_ok    = (SIZE_W'(col) < SIZE_W'(MAX_WIDTH)) &&
                      (SIZE_W'(row) < SIZE_W'(MAX_HEIGHT));
  assign result_go  = !out_valid || out_ready;
  assign scan_last  = (cur_x == x1) && (cur_y == y1);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && op == OP_QUERY) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DIV_START;
      end
      ST_DIV_START: begin
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_next = (ch == CH_BLUE) ? ST_RESULT : ST_DIV_START;
        end
      end
      ST_RESULT: begin
        if (result_go) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready        = (state == ST_IDLE);
    store_req.we    = accept && (op == OP_LOAD) && load_ok;
    store_req.waddr = store_addr(row, col);
    store_req.wdata = {red_in, green_in, blue_in};
    store_req.re    = (state == ST_SCAN);
    store_req.raddr = store_addr(cur_y, cur_x);
    div_req.start   = (state == ST_DIV_START);
    div_req.divisor = cnt;
    case (ch)
      CH_RED:   div_req.dividend = rsum;
      CH_GREEN: div_req.dividend = gsum;
      default:  div_req.dividend = bsum;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= store_req.re;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_RESULT && result_go) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_query) begin
      q_col <= col;
      q_row <= row;
      x0    <= COL_W'(x0_c);
      x1    <= COL_W'(x1_c);
      y1    <= ROW_W'(y1_c);
      cur_x <= COL_W'(x0_c);
      cur_y <= ROW_W'(y0_c);
      rsum  <= '0;
      gsum  <= '0;
      bsum  <= '0;
      cnt   <= '0;
      ch    <= CH_RED;
    end else begin
      if (state == ST_SCAN) begin
        if (cur_x == x1) begin
          cur_x <= x0;
          cur_y <= cur_y + 1'b1;
        end else begin
          cur_x <= cur_x + 1'b1;
        end
      end
      if (rd_pend) begin
        rsum <= rsum + SUM_W'(store_rdata[PIX_W-1:2*CH_W]);
        gsum <= gsum + SUM_W'(store_rdata[2*CH_W-1:CH_W]);
        bsum <= bsum + SUM_W'(store_rdata[CH_W-1:0]);
        cnt  <= cnt + 1'b1;
      end
      if (state == ST_DIV_WAIT && div_rsp.done) begin
        case (ch)
          CH_RED:   mean_r <= div_rsp.quotient;
          CH_GREEN: mean_g <= div_rsp.quotient;
          default:  mean_b <= div_rsp.quotient;
        endcase
        ch <= ch + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESULT && result_go) begin
      out_col   <= q_col;
      out_row   <= q_row;
      red_out   <= mean_r;
      green_out <= mean_g;
      blue_out  <= mean_b;
    end
  end

endmodule

/* hdl/clipped_box_blur.sv */
// ----------------------------------------------------------------------------
// Clipped box blur
// Frame store with a box blur over a square window clipped to the region.
//
// Channel  Signals                                        Role
// in       in_valid/in_ready, op col row red/green/blue_in  load or query item
// out      out_valid/out_ready, out_col out_row *_out       blurred pixel item
// cfg      cfg_valid/cfg_ready, cfg_index cfg_data          register write
//
// A load is written to the frame store as it is accepted. A query takes one
// read of the frame store per window pixel, then a drain and three 8-step
// divisions on the shared divider; a full window is 15 by 15.
// Reset restores the register defaults; the frame store is not cleared.
// A finished item waits in the output register while the next load is taken;
// a following query holds in its last step until that register frees.
// ----------------------------------------------------------------------------
`include "clipped_box_blur_macros.svh"

module clipped_box_blur (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            op,
  input  logic [cbb_pkg::COL_W-1:0]       col,
  input  logic [cbb_pkg::ROW_W-1:0]       row,
  input  logic [cbb_pkg::CH_W-1:0]        red_in,
  input  logic [cbb_pkg::CH_W-1:0]        green_in,
  input  logic [cbb_pkg::CH_W-1:0]        blue_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [cbb_pkg::COL_W-1:0]       out_col,
  output logic [cbb_pkg::ROW_W-1:0]       out_row,
  output logic [cbb_pkg::CH_W-1:0]        red_out,
  output logic [cbb_pkg::CH_W-1:0]        green_out,
  output logic [cbb_pkg::CH_W-1:0]        blue_out,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cbb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cbb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cbb_pkg::*;

  cbb_cfg_t       cfg;
  cbb_store_req_t store_req;
  logic [PIX_W-1:0] store_rdata;
  cbb_div_req_t   div_req;
  cbb_div_rsp_t   div_rsp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= SIZE_W'(64);
      cfg.height <= SIZE_W'(64);
      cfg.radius <= RAD_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_REGION_WIDTH:  cfg.width  <= cfg_data[SIZE_W-1:0];
        CFG_REGION_HEIGHT: cfg.height <= cfg_data[SIZE_W-1:0];
        CFG_BLUR_RADIUS:   cfg.radius <= cfg_data[RAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cbb_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .col         (col),
    .row         (row),
    .red_in      (red_in),
    .green_in    (green_in),
    .blue_in     (blue_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_col     (out_col),
    .out_row     (out_row),
    .red_out     (red_out),
    .green_out   (green_out),
    .blue_out    (blue_out),
    .store_req   (store_req),
    .store_rdata (store_rdata),
    .div_req     (div_req),
    .div_rsp     (div_rsp)
  );

  cbb_store u_store (
    .clk   (clk),
    .req   (store_req),
    .rdata (store_rdata)
  );

  cbb_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  `CBB_ASSERT_NEXT(a_query_holds_input, in_valid && in_ready && op == OP_QUERY, !in_ready, "query item did not block the input")
  `CBB_ASSERT_NOW(a_store_no_clash, store_req.we, !store_req.re, "frame store written during a window scan")
  `CBB_ASSERT_NOW(a_div_start_free, div_req.start, !div_rsp.busy, "divider started while busy")

endmodule
